// ===== hdl/pfdm_pkg.sv =====
`timescale 1ns / 1ps

package pfdm_pkg;

	localparam int CAPTURE_BITS  = 16;
	localparam int TIME_BITS     = 32;
	localparam int OVF_BITS      = TIME_BITS - CAPTURE_BITS;
	localparam int RATE_BITS     = 24;
	localparam int FREQ_LIM_BITS = 20;
	localparam int TIMEOUT_BITS  = 16;
	localparam int PCT_BITS      = 7;
	localparam int PROD_BITS     = TIME_BITS + PCT_BITS;
	localparam int STEP_BITS     = $clog2(RATE_BITS + 1);
	localparam int OP_BITS       = 2;
	localparam int CFG_BITS      = 2;

	localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;

	localparam logic [OP_BITS-1:0] OP_EDGE = 2'd0;
	localparam logic [OP_BITS-1:0] OP_OVF  = 2'd1;
	localparam logic [OP_BITS-1:0] OP_TICK = 2'd2;

	localparam logic [CFG_BITS-1:0] CFG_RATE     = 2'd0;
	localparam logic [CFG_BITS-1:0] CFG_FREQ_MIN = 2'd1;
	localparam logic [CFG_BITS-1:0] CFG_FREQ_MAX = 2'd2;
	localparam logic [CFG_BITS-1:0] CFG_TIMEOUT  = 2'd3;

	localparam logic [RATE_BITS-1:0]     RATE_RST     = 24'd1000000;
	localparam logic [FREQ_LIM_BITS-1:0] FREQ_MIN_RST = 20'd100;
	localparam logic [FREQ_LIM_BITS-1:0] FREQ_MAX_RST = 20'd10000;
	localparam logic [TIMEOUT_BITS-1:0]  TIMEOUT_RST  = 16'd1000;

	typedef struct packed {
		logic [OP_BITS-1:0]      op;
		logic [CAPTURE_BITS-1:0] capture_count;
	} evt_t;

	typedef struct packed {
		logic [RATE_BITS-1:0] freq_hz;
		logic [PCT_BITS-1:0]  duty_pct;
		logic                 has_signal;
		logic                 arm_falling;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FREQ,
		ST_MUL,
		ST_DUTY_GO,
		ST_DUTY,
		ST_POST
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic div_start;
		logic div_duty;
		logic latch_f;
		logic mul;
		logic set_zero;
		logic set_sat;
		logic set_div;
		logic post;
	} ctrl_cmd_t;

	typedef struct packed {
		logic measure;
		logic div_done;
		logic in_range;
		logic sat;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== hdl/pfdm_div.sv =====
`timescale 1ns / 1ps

module pfdm_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pfdm_pkg::STEP_BITS-1:0] steps,
	input  logic [pfdm_pkg::TIME_BITS-1:0] rem_init,
	input  logic [pfdm_pkg::RATE_BITS-1:0] dvd_init,
	input  logic [pfdm_pkg::TIME_BITS-1:0] divisor,
	output logic                           done,
	output logic [pfdm_pkg::RATE_BITS-1:0] quot
);
	import pfdm_pkg::*;

	logic                 busy_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [RATE_BITS-1:0] dvd_q;
	logic [TIME_BITS-1:0] dsr_q;
	logic [RATE_BITS-1:0] quot_q;

	logic [TIME_BITS:0] rem_sh;
	logic [TIME_BITS:0] diff;
	logic               ge;
	logic               step;

	assign rem_sh = {rem_q, dvd_q[RATE_BITS-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};
	assign diff   = rem_sh - {1'b0, dsr_q};
	assign step   = busy_q && (cnt_q != '0);
	assign done   = busy_q && (cnt_q == '0);
	assign quot   = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (step) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			dvd_q  <= dvd_init;
			dsr_q  <= divisor;
			quot_q <= '0;
		end else if (step) begin
			rem_q  <= ge ? diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
			dvd_q  <= {dvd_q[RATE_BITS-2:0], 1'b0};
			quot_q <= {quot_q[RATE_BITS-2:0], ge};
		end
	end

endmodule

// ===== hdl/pfdm_dp.sv =====
`timescale 1ns / 1ps

module pfdm_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pfdm_pkg::evt_t                 evt,
	input  logic                           cfg_valid,
	input  logic [pfdm_pkg::CFG_BITS-1:0]  cfg_index,
	input  logic [pfdm_pkg::RATE_BITS-1:0] cfg_data,
	input  pfdm_pkg::ctrl_cmd_t            cmd,
	output pfdm_pkg::dp_stat_t             stat,
	output pfdm_pkg::res_t                 res,
	output logic                           res_valid,
	input  logic                           res_stall
);
	import pfdm_pkg::*;

	logic [RATE_BITS-1:0]     rate_q;
	logic [FREQ_LIM_BITS-1:0] fmin_q;
	logic [FREQ_LIM_BITS-1:0] fmax_q;
	logic [TIMEOUT_BITS-1:0]  timeout_q;

	logic                    phase_q;
	logic [OVF_BITS-1:0]     ovf_q;
	logic [TIME_BITS-1:0]    prev_rise_q;
	logic                    prev_valid_q;
	logic [TIME_BITS-1:0]    cur_rise_q;
	logic [TIME_BITS-1:0]    high_q;
	logic [RATE_BITS-1:0]    freq_q;
	logic [PCT_BITS-1:0]     duty_q;
	logic                    signal_q;
	logic [TIMEOUT_BITS-1:0] idle_q;

	evt_t                 evt_q;
	logic [TIME_BITS-1:0] period_q;
	logic [RATE_BITS-1:0] f_q;
	logic [PROD_BITS-1:0] prod_q;
	res_t                 res_q;
	logic                 res_valid_q;

	logic [TIME_BITS-1:0]    ts;
	logic [TIME_BITS-1:0]    period;
	logic [TIMEOUT_BITS-1:0] idle_n;
	logic                    is_edge;

	logic                 div_done;
	logic [RATE_BITS-1:0] div_quot;
	logic [STEP_BITS-1:0] div_steps;
	logic [TIME_BITS-1:0] div_rem;
	logic [RATE_BITS-1:0] div_dvd;
	logic [TIME_BITS-1:0] div_dsr;

	assign ts      = {ovf_q, evt_q.capture_count};
	assign period  = ts - prev_rise_q;
	assign idle_n  = idle_q + 1'b1;
	assign is_edge = evt_q.op == OP_EDGE;

	assign stat.measure  = is_edge && !phase_q && prev_valid_q && (period != '0);
	assign stat.div_done = div_done;
	assign stat.in_range = (f_q >= {{(RATE_BITS-FREQ_LIM_BITS){1'b0}}, fmin_q})
		&& (f_q <= {{(RATE_BITS-FREQ_LIM_BITS){1'b0}}, fmax_q});
	assign stat.sat      = high_q >= period_q;
	assign stat.out_free = !res_valid_q || !res_stall;

	always_comb begin
		if (cmd.div_duty) begin
			div_steps = STEP_BITS'(PCT_BITS);
			div_rem   = prod_q[PROD_BITS-1:PCT_BITS];
			div_dvd   = {prod_q[PCT_BITS-1:0], {(RATE_BITS-PCT_BITS){1'b0}}};
			div_dsr   = period_q;
		end else begin
			div_steps = STEP_BITS'(RATE_BITS);
			div_rem   = '0;
			div_dvd   = rate_q;
			div_dsr   = period;
		end
	end

	pfdm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.steps    (div_steps),
		.rem_init (div_rem),
		.dvd_init (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= RATE_RST;
			fmin_q    <= FREQ_MIN_RST;
			fmax_q    <= FREQ_MAX_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RATE:     rate_q    <= cfg_data;
				CFG_FREQ_MIN: fmin_q    <= cfg_data[FREQ_LIM_BITS-1:0];
				CFG_FREQ_MAX: fmax_q    <= cfg_data[FREQ_LIM_BITS-1:0];
				CFG_TIMEOUT:  timeout_q <= cfg_data[TIMEOUT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= 1'b0;
			ovf_q        <= '0;
			prev_rise_q  <= '0;
			prev_valid_q <= 1'b0;
			cur_rise_q   <= '0;
			high_q       <= '0;
			freq_q       <= '0;
			duty_q       <= '0;
			signal_q     <= 1'b0;
			idle_q       <= '0;
		end else begin
			if (cmd.exec) begin
				case (evt_q.op)
					OP_EDGE: begin
						if (phase_q) begin
							high_q       <= ts - cur_rise_q;
							phase_q      <= 1'b0;
							prev_rise_q  <= cur_rise_q;
							prev_valid_q <= 1'b1;
						end else begin
							cur_rise_q <= ts;
							phase_q    <= 1'b1;
							if (prev_valid_q) begin
								signal_q <= 1'b1;
								idle_q   <= '0;
							end
						end
					end
					OP_OVF: ovf_q <= ovf_q + 1'b1;
					OP_TICK: begin
						if (signal_q) begin
							if (idle_n >= timeout_q) begin
								freq_q       <= '0;
								duty_q       <= '0;
								signal_q     <= 1'b0;
								idle_q       <= '0;
								prev_valid_q <= 1'b0;
								phase_q      <= 1'b0;
							end else begin
								idle_q <= idle_n;
							end
						end
					end
					default: ;
				endcase
			end
			if (cmd.set_zero) begin
				freq_q <= '0;
				duty_q <= '0;
			end
			if (cmd.set_sat) begin
				freq_q <= f_q;
				duty_q <= PCT_FULL;
			end
			if (cmd.set_div) begin
				freq_q <= f_q;
				duty_q <= div_quot[PCT_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			evt_q <= evt;
		end
		if (cmd.exec) begin
			period_q <= period;
		end
		if (cmd.latch_f) begin
			f_q <= div_quot;
		end
		if (cmd.mul) begin
			prod_q <= PROD_BITS'(high_q) * PROD_BITS'(PCT_FULL);
		end
		if (cmd.post) begin
			res_q.freq_hz     <= freq_q;
			res_q.duty_pct    <= duty_q;
			res_q.has_signal  <= signal_q;
			res_q.arm_falling <= phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.post) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

// ===== hdl/pfdm_ctrl.sv =====
`timescale 1ns / 1ps

module pfdm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                evt_valid,
	output logic                evt_stall,
	input  pfdm_pkg::dp_stat_t  stat,
	output pfdm_pkg::ctrl_cmd_t cmd
);
	import pfdm_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		evt_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				evt_stall = 1'b0;
				if (evt_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.measure) begin
					cmd.div_start = 1'b1;
					state_n       = ST_FREQ;
				end else begin
					state_n = ST_POST;
				end
			end
			ST_FREQ: begin
				if (stat.div_done) begin
					cmd.latch_f = 1'b1;
					state_n     = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				if (!stat.in_range) begin
					cmd.set_zero = 1'b1;
					state_n      = ST_POST;
				end else if (stat.sat) begin
					cmd.set_sat = 1'b1;
					state_n     = ST_POST;
				end else begin
					state_n = ST_DUTY_GO;
				end
			end
			ST_DUTY_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_duty  = 1'b1;
				state_n       = ST_DUTY;
			end
			ST_DUTY: begin
				if (stat.div_done) begin
					cmd.set_div = 1'b1;
					state_n     = ST_POST;
				end
			end
			ST_POST: begin
				if (stat.out_free) begin
					cmd.post = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

// ===== hdl/pulse_frequency_duty_meter.sv =====
`timescale 1ns / 1ps
// overflow, tick and non-measuring edges: load in idle, exec, then post to the result register
// a rising edge that closes a nonzero period also runs the divider: one shared restoring
// divider gives one quotient bit a cycle, 24 quotient bits for frequency and 7 for duty
// one item at a time; the next item is taken while the last result waits
// reset: all measurement state cleared, registers back to defaults, no clearing pass

module pulse_frequency_duty_meter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           evt_valid,
	output logic                           evt_stall,
	input  pfdm_pkg::evt_t                 evt,
	output logic                           res_valid,
	input  logic                           res_stall,
	output pfdm_pkg::res_t                 res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pfdm_pkg::CFG_BITS-1:0]  cfg_index,
	input  logic [pfdm_pkg::RATE_BITS-1:0] cfg_data
);
	import pfdm_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	pfdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pfdm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

endmodule

// ===== sim/pfdm_checker.sv =====
`timescale 1ns / 1ps

module pfdm_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           evt_valid,
	input  logic                           evt_stall,
	input  pfdm_pkg::evt_t                 evt,
	input  logic                           res_valid,
	input  logic                           res_stall,
	input  pfdm_pkg::res_t                 res,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [pfdm_pkg::CFG_BITS-1:0]  cfg_index,
	input  logic [pfdm_pkg::RATE_BITS-1:0] cfg_data,
	output int                             mismatches,
	output int                             readings_due
);

	import pfdm_pkg::*;

	logic [RATE_BITS-1:0]     rate_q;
	logic [FREQ_LIM_BITS-1:0] fmin_q;
	logic [FREQ_LIM_BITS-1:0] fmax_q;
	logic [TIMEOUT_BITS-1:0]  tmo_q;

	logic                    armed_fall;
	logic [OVF_BITS-1:0]     ovf_cnt;
	logic [TIME_BITS-1:0]    last_rise;
	logic                    last_rise_ok;
	logic [TIME_BITS-1:0]    this_rise;
	logic [TIME_BITS-1:0]    high_t;
	logic [RATE_BITS-1:0]    freq_q;
	logic [PCT_BITS-1:0]     duty_q;
	logic                    sig_q;
	logic [TIMEOUT_BITS-1:0] idle_q;

	res_t readings[$];
	res_t want;

	function automatic res_t meter_update(input evt_t e);
		logic [TIME_BITS-1:0] ts;
		logic [TIME_BITS-1:0] period;
		logic [63:0]          f;
		logic [63:0]          d;
		res_t                 r;
		ts = {ovf_cnt, e.capture_count};
		case (e.op)
			OP_EDGE: begin
				if (armed_fall) begin
					high_t = ts - this_rise;
					armed_fall = 1'b0;
					last_rise = this_rise;
					last_rise_ok = 1'b1;
				end else begin
					this_rise = ts;
					armed_fall = 1'b1;
					if (last_rise_ok) begin
						period = this_rise - last_rise;
						// zero period keeps the last reading
						if (period != '0) begin
							f = 64'(rate_q);
							f = f / 64'(period);
							if (f >= 64'(fmin_q) && f <= 64'(fmax_q)) begin
								d = 64'(high_t);
								d = (d * 64'(PCT_FULL)) / 64'(period);
								if (d > 64'(PCT_FULL))
									d = 64'(PCT_FULL);
								freq_q = f[RATE_BITS-1:0];
								duty_q = d[PCT_BITS-1:0];
							end else begin
								freq_q = '0;
								duty_q = '0;
							end
						end
						sig_q = 1'b1;
						idle_q = '0;
					end
				end
			end
			OP_OVF: ovf_cnt = ovf_cnt + 1'b1;
			OP_TICK: begin
				if (sig_q) begin
					idle_q = idle_q + 1'b1;
					if (idle_q >= tmo_q) begin
						freq_q = '0;
						duty_q = '0;
						sig_q = 1'b0;
						idle_q = '0;
						last_rise_ok = 1'b0;
						armed_fall = 1'b0;
					end
				end
			end
			default: ;
		endcase
		r.freq_hz = freq_q;
		r.duty_pct = duty_q;
		r.has_signal = sig_q;
		r.arm_falling = armed_fall;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q = RATE_RST;
			fmin_q = FREQ_MIN_RST;
			fmax_q = FREQ_MAX_RST;
			tmo_q = TIMEOUT_RST;
			armed_fall = 1'b0;
			ovf_cnt = '0;
			last_rise = '0;
			last_rise_ok = 1'b0;
			this_rise = '0;
			high_t = '0;
			freq_q = '0;
			duty_q = '0;
			sig_q = 1'b0;
			idle_q = '0;
			readings.delete();
			readings_due = 0;
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RATE:     rate_q = cfg_data;
					CFG_FREQ_MIN: fmin_q = cfg_data[FREQ_LIM_BITS-1:0];
					CFG_FREQ_MAX: fmax_q = cfg_data[FREQ_LIM_BITS-1:0];
					CFG_TIMEOUT:  tmo_q = cfg_data[TIMEOUT_BITS-1:0];
					default: ;
				endcase
			end
			if (evt_valid && !evt_stall)
				readings.push_back(meter_update(evt));
			if (res_valid && !res_stall) begin
				if (readings.size() == 0) begin
					$error("unexpected result item: freq_hz %0d duty_pct %0d", res.freq_hz,
						res.duty_pct);
					mismatches++;
				end else begin
					want = readings.pop_front();
					if (res.freq_hz !== want.freq_hz) begin
						$error("freq_hz: expected %0d, got %0d", want.freq_hz, res.freq_hz);
						mismatches++;
					end
					if (res.duty_pct !== want.duty_pct) begin
						$error("duty_pct: expected %0d, got %0d", want.duty_pct, res.duty_pct);
						mismatches++;
					end
					if (res.has_signal !== want.has_signal) begin
						$error("has_signal: expected %0b, got %0b", want.has_signal,
							res.has_signal);
						mismatches++;
					end
					if (res.arm_falling !== want.arm_falling) begin
						$error("arm_falling: expected %0b, got %0b", want.arm_falling,
							res.arm_falling);
						mismatches++;
					end
				end
			end
			readings_due = readings.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

	import pfdm_pkg::*;

	localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
	localparam int LIMIT = 500000;
	localparam int HOLD_CYCLES = 200;

	logic                  clk;
	logic                  arst_n;
	logic                  evt_valid;
	logic                  evt_stall;
	evt_t                  evt;
	logic                  res_valid;
	logic                  res_stall;
	res_t                  res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_BITS-1:0]   cfg_index;
	logic [RATE_BITS-1:0]  cfg_data;

	int                    mismatches;
	int                    readings_due;
	bit                    idle_en;
	int                    hold_req;
	int                    hold_seen;
	int                    hold_left;
	int unsigned           items_sent = 0;
	int unsigned           cycle_cnt = 0;
	logic [CAPTURE_BITS-1:0] tcnt;

	pulse_frequency_duty_meter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pfdm_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt_valid    (evt_valid),
		.evt_stall    (evt_stall),
		.evt          (evt),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.readings_due (readings_due)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: random stalls plus an occasional long hold-off
	initial begin
		res_stall = 1'b0;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
				res_stall <= 1'b1;
			end else begin
				res_stall <= idle_en && ($urandom_range(0, 99) < 9);
			end
		end
	end

	task automatic send_event(input logic [OP_BITS-1:0] op, input logic [CAPTURE_BITS-1:0] cnt);
		evt_t e;
		e.op = op;
		e.capture_count = cnt;
		while (idle_en && $urandom_range(0, 99) < 9) begin
			evt_valid <= 1'b0;
			@(negedge clk);
		end
		evt_valid <= 1'b1;
		evt <= e;
		do @(posedge clk); while (evt_stall);
		items_sent++;
		@(negedge clk);
	endtask

	// move the capture counter on, reporting each wrap as an overflow item
	task automatic advance(input int unsigned dt);
		longint unsigned total;
		total = longint'(tcnt) + dt;
		while (total >= 65536) begin
			send_event(OP_OVF, CAPTURE_BITS'($urandom));
			total -= 65536;
		end
		tcnt = total[CAPTURE_BITS-1:0];
	endtask

	task automatic edge_after(input int unsigned dt);
		advance(dt);
		send_event(OP_EDGE, tcnt);
	endtask

	task automatic ticks(input int n);
		repeat (n) send_event(OP_TICK, CAPTURE_BITS'($urandom));
	endtask

	function automatic int unsigned pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 0;
		else if (r < 15)
			return $urandom_range(1, 50);
		else if (r < 85)
			return $urandom_range(50, 15000);
		else
			return $urandom_range(15000, 300000);
	endfunction

	task automatic pulse_train();
		int unsigned p;
		int unsigned hi;
		int          n;
		p = pick_period();
		n = $urandom_range(2, 8);
		for (int k = 0; k < n; k++) begin
			hi = $urandom_range(0, p);
			edge_after(p - hi);
			edge_after(hi);
			if ($urandom_range(0, 9) == 0)
				ticks($urandom_range(1, 3));
		end
	endtask

	task automatic drain();
		evt_valid <= 1'b0;
		while (readings_due != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_BITS-1:0] idx, input logic [RATE_BITS-1:0] val,
		input int w);
		logic [31:0] junk;
		junk = $urandom << w;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= junk[RATE_BITS-1:0] | val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic configure(input logic [RATE_BITS-1:0] rate, input logic [19:0] fmin,
		input logic [19:0] fmax, input logic [15:0] tmo);
		drain();
		write_reg(CFG_RATE, rate, RATE_BITS);
		write_reg(CFG_FREQ_MIN, RATE_BITS'(fmin), FREQ_LIM_BITS);
		write_reg(CFG_FREQ_MAX, RATE_BITS'(fmax), FREQ_LIM_BITS);
		write_reg(CFG_TIMEOUT, RATE_BITS'(tmo), TIMEOUT_BITS);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [RATE_BITS-1:0] rate, input logic [19:0] fmin,
		input logic [19:0] fmax, input logic [15:0] tmo, input int unsigned n, input bit quiet);
		int unsigned start;
		bit          held;
		int          r;
		configure(rate, fmin, fmax, tmo);
		idle_en = !quiet;
		start = items_sent;
		held = 1'b0;
		while (items_sent - start < n) begin
			if (!held && items_sent - start >= n / 2) begin
				hold_req++;
				held = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 70)
				pulse_train();
			else if (r < 80)
				ticks($urandom_range(1, 6));
			else if (r < 88)
				send_event(OP_EDGE, CAPTURE_BITS'($urandom));
			else if (r < 94)
				repeat ($urandom_range(1, 3)) send_event(OP_OVF, CAPTURE_BITS'($urandom));
			else if (r < 97)
				send_event(OP_UNUSED, CAPTURE_BITS'($urandom));
			else begin
				// back-to-back edges on one timestamp
				edge_after(0);
				edge_after(0);
				edge_after(0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		evt_valid = 1'b0;
		evt = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tcnt = '0;
		idle_en = 1'b1;
		hold_req = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default settings: 1 MHz count, 100 Hz to 10 kHz
		send_event(OP_TICK, 16'hFFFF);
		send_event(OP_UNUSED, 16'h5A5A);
		send_event(OP_EDGE, 16'd0);
		send_event(OP_EDGE, 16'd250);
		send_event(OP_EDGE, 16'd1000);
		send_event(OP_EDGE, 16'd1000);
		send_event(OP_EDGE, 16'd1000);
		send_event(OP_EDGE, 16'd1020);
		send_event(OP_EDGE, 16'd1050);
		// fall before rise, high time wraps and duty saturates
		send_event(OP_EDGE, 16'd1000);
		send_event(OP_EDGE, 16'd6050);
		ticks(3);
		send_event(OP_OVF, 16'h0000);
		send_event(OP_EDGE, 16'hFFFF);
		send_event(OP_OVF, 16'hFFFF);
		send_event(OP_EDGE, 16'h0000);
		send_event(OP_EDGE, 16'hA5A5);
		send_event(OP_UNUSED, 16'hFFFF);
		send_event(OP_TICK, 16'h0000);

		run_phase(24'd1000000, 20'd0, 20'd1000000, 16'd4, 150, 1'b0);
		run_phase(24'hFFFFFF, 20'd1000, 20'd1000000, 16'd1, 140, 1'b1);
		run_phase(24'd0, 20'd0, 20'd0, 16'd0, 110, 1'b0);
		run_phase(24'd1000000, 20'd5000, 20'd200, 16'hFFFF, 110, 1'b0);
		run_phase(24'd1, 20'd0, 20'd1, 16'd3, 100, 1'b0);
		run_phase(24'd1000000, 20'd1000000, 20'd1000000, 16'd2, 100, 1'b0);
		run_phase(RATE_BITS'($urandom_range(1, 24'hFFFFFF)),
			FREQ_LIM_BITS'($urandom_range(0, 2000)),
			FREQ_LIM_BITS'($urandom_range(2000, 1000000)),
			TIMEOUT_BITS'($urandom_range(1, 10)), 120, 1'b0);

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
